// File: design/lpd_pkg.sv
// Shared types, constants and lookup tables for the link packet deframer.
// Used by the classifier, the sequencer, the result queue, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

   // Default depth of the result queue. It must be a power of two, at least 2.
   localparam int LPD_QUEUE_DEPTH = 4;

   // Table sizes.
   localparam int N_MACHINE = 20;
   localparam int N_COMMAND = 18;

   // Machine ids at this table position and above talk from calculator to host.
   localparam int MID_UPLINK_FIRST = 10;

   // Special byte values.
   localparam logic [7:0] MARKER_BYTE  = 8'h98;
   localparam logic [7:0] RESYNC_CMD_A = 8'h15;
   localparam logic [7:0] RESYNC_CMD_B = 8'h56;

   // Result kinds.
   localparam logic [2:0] KIND_MID    = 3'd0;
   localparam logic [2:0] KIND_CMD    = 3'd1;
   localparam logic [2:0] KIND_LEN_LO = 3'd2;
   localparam logic [2:0] KIND_LEN_HI = 3'd3;
   localparam logic [2:0] KIND_DATA   = 3'd4;
   localparam logic [2:0] KIND_CHK_LO = 3'd5;
   localparam logic [2:0] KIND_CHK_HI = 3'd6;
   localparam logic [2:0] KIND_ERROR  = 3'd7;

   // Error codes.
   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_UNKNOWN_MID = 2'd1;
   localparam logic [1:0] ERR_UNKNOWN_CMD = 2'd2;

   // Machine id table, searched first match.
   localparam logic [7:0] MID_TABLE [N_MACHINE] = '{
      8'h00, 8'h02, 8'h03, 8'h05, 8'h06, 8'h07, 8'h08, 8'h08, 8'h09, 8'h23,
      8'h00, 8'h82, 8'h83, 8'h85, 8'h86, 8'h74, 8'h98, 8'h88, 8'h89, 8'h73
   };

   // Command id table, searched first match.
   localparam logic [7:0] CID_TABLE [N_COMMAND] = '{
      8'h06, 8'h09, 8'h15, 8'h2d, 8'h36, 8'h47, 8'h56, 8'h5A, 8'h68,
      8'h6D, 8'h74, 8'h78, 8'h87, 8'h88, 8'h92, 8'hA2, 8'hB7, 8'hC9
   };

   // Commands that are followed by data and a checksum.
   localparam logic CID_HAS_DATA [N_COMMAND] = '{
      1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1
   };

   // One result item.
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
      logic       direction;
      logic [4:0] command_index;
      logic       resync;
      logic [1:0] error_code;
      logic       last;
   } rsp_type;

   // Table lookups for one byte.
   typedef struct packed {
      logic       mid_hit;
      logic       mid_dir;
      logic       cid_hit;
      logic [4:0] cid_idx;
      logic       cid_data;
   } class_type;

   // Up to two results written into the queue in one transfer.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic rsp_type make_rsp(input logic [2:0] kind, input logic [7:0] value,
                                        input logic dir, input logic [4:0] cmd,
                                        input logic rs, input logic [1:0] err,
                                        input logic last);
      rsp_type r;
      r.kind          = kind;
      r.value         = value;
      r.direction     = dir;
      r.command_index = cmd;
      r.resync        = rs;
      r.error_code    = err;
      r.last          = last;
      return r;
   endfunction

endpackage

`default_nettype wire

// File: design/lpd_classify.sv
// Byte classifier: first-match lookups of one byte in the machine and command tables.
// Depends on lpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpd_classify
   import lpd_pkg::*;
(
   input  wire logic [7:0] byte_value,
   output class_type       info
);

   // Scan from the top down so the lowest matching index wins.
   always_comb begin
      info = '0;
      for (int i = N_MACHINE - 1; i >= 0; i--) begin
         if (MID_TABLE[i] == byte_value) begin
            info.mid_hit = 1'b1;
            info.mid_dir = (i >= MID_UPLINK_FIRST);
         end
      end
      for (int j = N_COMMAND - 1; j >= 0; j--) begin
         if (CID_TABLE[j] == byte_value) begin
            info.cid_hit  = 1'b1;
            info.cid_idx  = 5'(j);
            info.cid_data = CID_HAS_DATA[j];
         end
      end
   end

endmodule

`default_nettype wire

// File: design/lpd_sequencer.sv
// Packet sequencer: tracks the packet phase, holds back a data marker and emits
// zero, one or two results for each accepted byte. Depends on lpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpd_sequencer
   import lpd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] byte_value,
   input  wire class_type  info,
   output push_type        push
);

   typedef enum logic [6:0] {
      PH_MID   = 7'b0000001,
      PH_CID   = 7'b0000010,
      PH_LENLO = 7'b0000100,
      PH_LENHI = 7'b0001000,
      PH_DATA  = 7'b0010000,
      PH_CHKLO = 7'b0100000,
      PH_CHKHI = 7'b1000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        dir_ff, dir_in;
   logic [4:0]  cmd_ff, cmd_in;
   logic        data_ff, data_in;
   logic [7:0]  len_lo_ff, len_lo_in;
   logic [15:0] remain_ff, remain_in;
   logic        pending_ff, pending_in;
   logic        halted_ff, halted_in;

   logic        resync_byte;
   logic        take_byte;
   logic        byte_vld;
   rsp_type     byte_res;
   logic [15:0] remain_dec;
   logic [15:0] length_full;

   assign resync_byte = pending_ff && (byte_value == RESYNC_CMD_A || byte_value == RESYNC_CMD_B);
   assign take_byte   = accept && !halted_ff && !resync_byte;
   assign remain_dec  = remain_ff - 16'd1;
   assign length_full = {byte_value, len_lo_ff};

   // Next state and the results of one byte.
   always_comb begin
      phase_in   = phase_ff;
      dir_in     = dir_ff;
      cmd_in     = cmd_ff;
      data_in    = data_ff;
      len_lo_in  = len_lo_ff;
      remain_in  = remain_ff;
      pending_in = pending_ff;
      halted_in  = halted_ff;
      byte_vld   = 1'b0;
      byte_res   = '0;
      push       = '0;

      // Normal handling of the byte in its own phase.
      if (take_byte) begin
         pending_in = 1'b0;
         byte_vld   = 1'b1;
         case (phase_ff)
            PH_MID: begin
               if (!info.mid_hit) begin
                  byte_res  = make_rsp(KIND_ERROR, byte_value, 1'b0, 5'd0, 1'b0,
                                       ERR_UNKNOWN_MID, 1'b0);
                  halted_in = 1'b1;
               end else begin
                  byte_res = make_rsp(KIND_MID, byte_value, info.mid_dir, 5'd0, 1'b0,
                                      ERR_NONE, 1'b0);
                  dir_in   = info.mid_dir;
                  cmd_in   = 5'd0;
                  phase_in = PH_CID;
               end
            end
            PH_CID: begin
               if (!info.cid_hit) begin
                  byte_res  = make_rsp(KIND_ERROR, byte_value, dir_ff, 5'd0, 1'b0,
                                       ERR_UNKNOWN_CMD, 1'b0);
                  halted_in = 1'b1;
               end else begin
                  byte_res = make_rsp(KIND_CMD, byte_value, dir_ff, info.cid_idx, 1'b0,
                                      ERR_NONE, 1'b0);
                  cmd_in   = info.cid_idx;
                  data_in  = info.cid_data;
                  phase_in = PH_LENLO;
               end
            end
            PH_LENLO: begin
               byte_res  = make_rsp(KIND_LEN_LO, byte_value, dir_ff, cmd_ff, 1'b0,
                                    ERR_NONE, 1'b0);
               len_lo_in = byte_value;
               phase_in  = PH_LENHI;
            end
            PH_LENHI: begin
               byte_res  = make_rsp(KIND_LEN_HI, byte_value, dir_ff, cmd_ff, 1'b0,
                                    ERR_NONE, !data_ff);
               remain_in = length_full;
               if (!data_ff) begin
                  phase_in = PH_MID;
               end else if (length_full == 16'd0) begin
                  phase_in = PH_CHKLO;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               remain_in = remain_dec;
               if (remain_dec == 16'd0) begin
                  phase_in = PH_CHKLO;
               end
               // A marker is held until the next byte shows what it means.
               if (byte_value == MARKER_BYTE) begin
                  pending_in = 1'b1;
                  byte_vld   = 1'b0;
               end else begin
                  byte_res = make_rsp(KIND_DATA, byte_value, dir_ff, cmd_ff, 1'b0,
                                      ERR_NONE, 1'b0);
               end
            end
            PH_CHKLO: begin
               byte_res = make_rsp(KIND_CHK_LO, byte_value, dir_ff, cmd_ff, 1'b0,
                                   ERR_NONE, 1'b0);
               phase_in = PH_CHKHI;
            end
            PH_CHKHI: begin
               byte_res = make_rsp(KIND_CHK_HI, byte_value, dir_ff, cmd_ff, 1'b0,
                                   ERR_NONE, 1'b1);
               phase_in = PH_MID;
            end
            default: begin
               byte_vld = 1'b0;
               phase_in = PH_MID;
            end
         endcase
      end

      // Put the results in order for the queue.
      if (accept && !halted_ff) begin
         if (resync_byte) begin
            // The held marker opens a new header and this byte is its command.
            push.count  = 2'd2;
            push.first  = make_rsp(KIND_MID, MARKER_BYTE, 1'b1, 5'd0, 1'b1, ERR_NONE, 1'b0);
            push.second = make_rsp(KIND_CMD, byte_value, 1'b1, info.cid_idx, 1'b0,
                                   ERR_NONE, 1'b0);
            pending_in  = 1'b0;
            dir_in      = 1'b1;
            cmd_in      = info.cid_idx;
            data_in     = info.cid_data;
            phase_in    = PH_LENLO;
         end else if (pending_ff) begin
            // The held marker was plain data.
            push.count  = byte_vld ? 2'd2 : 2'd1;
            push.first  = make_rsp(KIND_DATA, MARKER_BYTE, dir_ff, cmd_ff, 1'b0,
                                   ERR_NONE, 1'b0);
            push.second = byte_res;
         end else begin
            push.count = {1'b0, byte_vld};
            push.first = byte_res;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MID;
         dir_ff     <= 1'b0;
         cmd_ff     <= 5'd0;
         data_ff    <= 1'b0;
         len_lo_ff  <= 8'd0;
         remain_ff  <= 16'd0;
         pending_ff <= 1'b0;
         halted_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         dir_ff     <= dir_in;
         cmd_ff     <= cmd_in;
         data_ff    <= data_in;
         len_lo_ff  <= len_lo_in;
         remain_ff  <= remain_in;
         pending_ff <= pending_in;
         halted_ff  <= halted_in;
      end
   end

endmodule

`default_nettype wire

// File: design/lpd_result_queue.sv
// Result queue: takes up to two results per cycle, hands out at most one per cycle.
// Depends on lpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpd_result_queue
   import lpd_pkg::*;
#(
   parameter int QUEUE_DEPTH = LPD_QUEUE_DEPTH
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   input  wire logic     pop,
   output logic          full,
   output logic          empty,
   output rsp_type       head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_type             mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wptr_ff, wptr_in;
   logic [PTR_W-1:0]    rptr_ff, rptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PTR_W-1:0]    wptr_next;
   logic                rd;

   // Full leaves room for the two results one byte can cause.
   assign full      = (count_ff > CNT_W'(QUEUE_DEPTH - 2));
   assign empty     = (count_ff == '0);
   assign head      = mem[rptr_ff];
   assign rd        = pop && !empty;
   assign wptr_next = wptr_ff + 1'b1;

   // Pointer and fill count update.
   always_comb begin
      wptr_in  = wptr_ff + PTR_W'(push.count);
      rptr_in  = rptr_ff + PTR_W'(rd);
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Storage writes.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wptr_next] <= push.second;
      end
   end

endmodule

`default_nettype wire

// File: design/link_packet_deframer_top.sv
// Link packet deframer, top level: byte classifier, packet sequencer and result queue.
// Depends on lpd_pkg, lpd_classify, lpd_sequencer and lpd_result_queue.
//
// The deframer takes one link byte per cycle and tags it as machine id, command,
// length, data, checksum or error. A byte is taken whenever the result queue has room
// for two results, so with a reader that pops every cycle the block sustains one byte
// per cycle; a byte after a held 0x98 marker can give two results, and the single
// read port of the result queue, one result per cycle, is what sets the long-run rate
// then. A result is registered in the result queue before it shows on the rsp_ ports.
// After an unknown machine or command id the block reports one error and then drops
// every byte, without results, until reset.
`timescale 1ns / 1ps
`default_nettype none

module link_packet_deframer_top
   import lpd_pkg::*;
#(
   parameter int QUEUE_DEPTH = LPD_QUEUE_DEPTH
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_byte_value,
   output logic            empty,
   input  wire logic       pop,
   output logic [2:0]      rsp_kind,
   output logic [7:0]      rsp_value,
   output logic            rsp_direction,
   output logic [4:0]      rsp_command_index,
   output logic            rsp_resync,
   output logic [1:0]      rsp_error_code,
   output logic            rsp_last
);

   class_type info;
   push_type  push_q;
   rsp_type   head;
   logic      accept;

   assign accept = push && !full;

   // Table lookups.
   lpd_classify u_classify (
      .byte_value (req_byte_value),
      .info       (info)
   );

   // Packet phase tracking.
   lpd_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .byte_value (req_byte_value),
      .info       (info),
      .push       (push_q)
   );

   // Results waiting for transfer.
   lpd_result_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push_q),
      .pop   (pop),
      .full  (full),
      .empty (empty),
      .head  (head)
   );

   assign rsp_kind          = head.kind;
   assign rsp_value         = head.value;
   assign rsp_direction     = head.direction;
   assign rsp_command_index = head.command_index;
   assign rsp_resync        = head.resync;
   assign rsp_error_code    = head.error_code;
   assign rsp_last          = head.last;

endmodule

`default_nettype wire

// File: design/lpd_checker.sv
// Port-level checker for the link packet deframer, bound to the top level.
// Depends on lpd_pkg and link_packet_deframer_top.
`timescale 1ns / 1ps
`default_nettype none

module lpd_checker
   import lpd_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       full,
   input wire logic       empty,
   input wire logic [2:0] rsp_kind,
   input wire logic [7:0] rsp_value,
   input wire logic       rsp_resync,
   input wire logic [1:0] rsp_error_code,
   input wire logic       rsp_last
);

   // Reset leaves no result waiting and room for a transfer.
   a_reset_clears: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queue not cleared by reset");

   // Only a checksum high byte or a length high byte ends a packet.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last) |-> (rsp_kind == KIND_CHK_HI || rsp_kind == KIND_LEN_HI))
      else $error("last flag on a result that cannot end a packet");

   // A resync header always starts from the held marker.
   a_resync_marker: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_resync) |-> (rsp_kind == KIND_MID && rsp_value == MARKER_BYTE))
      else $error("resync flag on a result that is not a marker header");

   // An error code comes only with an error result, and always with one.
   a_error_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_kind == KIND_ERROR) == (rsp_error_code != ERR_NONE)))
      else $error("error code does not match result kind");

endmodule

bind link_packet_deframer_top lpd_checker u_lpd_checker (
   .clock          (clock),
   .reset          (reset),
   .full           (full),
   .empty          (empty),
   .rsp_kind       (rsp_kind),
   .rsp_value      (rsp_value),
   .rsp_resync     (rsp_resync),
   .rsp_error_code (rsp_error_code),
   .rsp_last       (rsp_last)
);

`default_nettype wire

// File: sim/tb_link_packet_deframer_top.sv
// Self-checking testbench for link_packet_deframer_top: byte stream in, tagged results out.
// A scoreboard class predicts every result from the accepted bytes; depends on lpd_pkg.
`timescale 1ns / 1ps

module tb_link_packet_deframer_top;
   import lpd_pkg::*;

   // Position of the next byte within a packet.
   typedef enum logic [2:0] {
      ST_MID, ST_CMD, ST_LEN_LO, ST_LEN_HI, ST_DATA, ST_CHK_LO, ST_CHK_HI
   } frame_state_type;

   localparam logic [7:0] NOT_AN_ID = 8'hFF;
   localparam int         RANDOM_BYTES = 1950;

   // Opening stream: downlink id with a data-less command and the largest length,
   // the last uplink id with a zero-length data command and a marker checksum,
   // then a marker id with held markers in the data, a resync that lands on the
   // checksum position, a zero-length packet and a marker at checksum high.
   localparam logic [7:0] OPENING_BYTES [22] = '{
      8'h00, 8'h09, 8'hFF, 8'hFF,
      8'h73, 8'h06, 8'h00, 8'h00, 8'h98, 8'h00,
      8'h98, 8'hC9, 8'h03, 8'h00, 8'h98, 8'h00, 8'h98, 8'h15, 8'h00, 8'h00,
      8'hFF, 8'h98
   };

   // Tracks the packet structure and holds the results still to come.
   class deframer_scoreboard;
      rsp_type         pending_rsp [$];
      frame_state_type state;
      logic            link_dir;
      logic [4:0]      cmd_idx;
      logic            has_data;
      logic [7:0]      len_low;
      logic [15:0]     remaining;
      logic            marker_held;
      logic            halted;
      int              mismatches;

      function new();
         state       = ST_MID;
         link_dir    = 1'b0;
         cmd_idx     = 5'd0;
         has_data    = 1'b0;
         len_low     = 8'd0;
         remaining   = 16'd0;
         marker_held = 1'b0;
         halted      = 1'b0;
         mismatches  = 0;
      endfunction

      // First matching table position, or the table size when absent.
      function int machine_slot(logic [7:0] b);
         int slot;
         slot = N_MACHINE;
         for (int i = N_MACHINE - 1; i >= 0; i--) begin
            if (MID_TABLE[i] == b) slot = i;
         end
         return slot;
      endfunction

      function int command_slot(logic [7:0] b);
         int slot;
         slot = N_COMMAND;
         for (int i = N_COMMAND - 1; i >= 0; i--) begin
            if (CID_TABLE[i] == b) slot = i;
         end
         return slot;
      endfunction

      function void add_expected(logic [2:0] kind, logic [7:0] value, logic dir,
                                 logic [4:0] cmd, logic rs, logic [1:0] err, logic last);
         rsp_type r;
         r.kind          = kind;
         r.value         = value;
         r.direction     = dir;
         r.command_index = cmd;
         r.resync        = rs;
         r.error_code    = err;
         r.last          = last;
         pending_rsp.push_back(r);
      endfunction

      function void take_machine_id(logic [7:0] b, logic rs);
         int slot;
         slot = machine_slot(b);
         if (slot == N_MACHINE) begin
            add_expected(KIND_ERROR, b, 1'b0, 5'd0, 1'b0, ERR_UNKNOWN_MID, 1'b0);
            halted = 1'b1;
            return;
         end
         link_dir = (slot >= MID_UPLINK_FIRST);
         cmd_idx  = 5'd0;
         add_expected(KIND_MID, b, link_dir, 5'd0, rs, ERR_NONE, 1'b0);
         state = ST_CMD;
      endfunction

      function void take_command(logic [7:0] b);
         int slot;
         slot = command_slot(b);
         if (slot == N_COMMAND) begin
            add_expected(KIND_ERROR, b, link_dir, 5'd0, 1'b0, ERR_UNKNOWN_CMD, 1'b0);
            halted = 1'b1;
            return;
         end
         cmd_idx  = slot[4:0];
         has_data = CID_HAS_DATA[slot];
         add_expected(KIND_CMD, b, link_dir, cmd_idx, 1'b0, ERR_NONE, 1'b0);
         state = ST_LEN_LO;
      endfunction

      // Ordinary handling of a byte at its position, with no marker held.
      function void take_in_phase(logic [7:0] b);
         case (state)
            ST_MID: take_machine_id(b, 1'b0);
            ST_CMD: take_command(b);
            ST_LEN_LO: begin
               len_low = b;
               add_expected(KIND_LEN_LO, b, link_dir, cmd_idx, 1'b0, ERR_NONE, 1'b0);
               state = ST_LEN_HI;
            end
            ST_LEN_HI: begin
               remaining = {b, len_low};
               add_expected(KIND_LEN_HI, b, link_dir, cmd_idx, 1'b0, ERR_NONE, !has_data);
               if (!has_data) state = ST_MID;
               else if (remaining == 16'd0) state = ST_CHK_LO;
               else state = ST_DATA;
            end
            ST_DATA: begin
               remaining = remaining - 16'd1;
               if (remaining == 16'd0) state = ST_CHK_LO;
               // A marker counts as data but waits for the next byte.
               if (b == MARKER_BYTE) marker_held = 1'b1;
               else add_expected(KIND_DATA, b, link_dir, cmd_idx, 1'b0, ERR_NONE, 1'b0);
            end
            ST_CHK_LO: begin
               add_expected(KIND_CHK_LO, b, link_dir, cmd_idx, 1'b0, ERR_NONE, 1'b0);
               state = ST_CHK_HI;
            end
            default: begin
               add_expected(KIND_CHK_HI, b, link_dir, cmd_idx, 1'b0, ERR_NONE, 1'b1);
               state = ST_MID;
            end
         endcase
      endfunction

      // Called for every byte transfer into the block.
      function void note_input(logic [7:0] b);
         if (halted) return;
         if (marker_held) begin
            marker_held = 1'b0;
            // The held marker opens a new header when a resync command follows.
            if (b == RESYNC_CMD_A || b == RESYNC_CMD_B) begin
               take_machine_id(MARKER_BYTE, 1'b1);
               if (!halted) take_command(b);
               return;
            end
            add_expected(KIND_DATA, MARKER_BYTE, link_dir, cmd_idx, 1'b0, ERR_NONE, 1'b0);
         end
         take_in_phase(b);
      endfunction

      function string show(rsp_type r);
         return $sformatf("kind=%0d value=%02h dir=%0d cmd=%0d resync=%0d err=%0d last=%0d",
                          r.kind, r.value, r.direction, r.command_index, r.resync,
                          r.error_code, r.last);
      endfunction

      function void note_mismatch(string msg);
         mismatches++;
         if (mismatches <= 10) $display("ERROR: %s", msg);
      endfunction

      // Called for every result transfer out of the block.
      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            note_mismatch({"unexpected result ", show(got)});
            return;
         end
         want = pending_rsp.pop_front();
         if (got.kind !== want.kind || got.value !== want.value ||
             got.direction !== want.direction || got.command_index !== want.command_index ||
             got.resync !== want.resync || got.error_code !== want.error_code ||
             got.last !== want.last) begin
            note_mismatch($sformatf("expected %s, got %s", show(want), show(got)));
         end
      endfunction

      // Anything still queued at the end never came out of the block.
      function void check_drained();
         int n;
         n = pending_rsp.size();
         if (n == 0) return;
         note_mismatch($sformatf("%0d results never arrived, oldest %s", n,
                                 show(pending_rsp[0])));
         mismatches += n - 1;
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       push;
   logic       full;
   logic [7:0] req_byte_value;
   logic       empty;
   logic       pop;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_value;
   logic       rsp_direction;
   logic [4:0] rsp_command_index;
   logic       rsp_resync;
   logic [1:0] rsp_error_code;
   logic       rsp_last;

   deframer_scoreboard sb;
   logic [15:0]        planned_len;
   bit                 steady_in;
   bit                 steady_out;

   link_packet_deframer_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_byte_value    (req_byte_value),
      .empty             (empty),
      .pop               (pop),
      .rsp_kind          (rsp_kind),
      .rsp_value         (rsp_value),
      .rsp_direction     (rsp_direction),
      .rsp_command_index (rsp_command_index),
      .rsp_resync        (rsp_resync),
      .rsp_error_code    (rsp_error_code),
      .rsp_last          (rsp_last)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly back to back, sometimes a short pause, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 72) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Chooses a byte that keeps the stream well formed, with markers and
   // resync commands placed often enough to abandon packets regularly.
   function automatic logic [7:0] pick_next_byte();
      logic [7:0] b;
      int         r;
      b = 8'($urandom);
      r = $urandom_range(99);
      if (sb.marker_held && r < 35) return $urandom_range(1) ? RESYNC_CMD_A : RESYNC_CMD_B;
      case (sb.state)
         ST_MID: b = MID_TABLE[$urandom_range(N_MACHINE - 1)];
         ST_CMD: b = CID_TABLE[$urandom_range(N_COMMAND - 1)];
         ST_LEN_LO: begin
            // Data packets stay short; a few are 256 bytes or longer.
            if (!sb.has_data) planned_len = 16'($urandom);
            else if (r < 2) planned_len = 16'h0100 + 16'($urandom_range(15));
            else if (r < 12) planned_len = 16'($urandom_range(9, 40));
            else planned_len = 16'($urandom_range(0, 8));
            b = planned_len[7:0];
         end
         ST_LEN_HI: b = planned_len[15:8];
         ST_DATA: if (r < 20) b = MARKER_BYTE;
         default: if (r < 15) b = MARKER_BYTE;
      endcase
      return b;
   endfunction

   // One byte transfer, followed by a random pause outside steady input stretches.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      push           <= 1'b1;
      req_byte_value <= b;
      do @(posedge clock); while (full !== 1'b0);
      sb.note_input(b);
      gap = steady_in ? 0 : pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stimulus and end of run.
   initial begin
      logic [7:0] bad_byte;
      int         drain_wait;
      sb = new();
      reset          <= 1'b1;
      push           <= 1'b0;
      req_byte_value <= 8'd0;
      planned_len     = 16'd0;
      steady_in       = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING_BYTES[k]) send_byte(OPENING_BYTES[k]);

      for (int item = 0; item < RANDOM_BYTES; item++) begin
         if (item % 100 == 0) steady_in = ($urandom_range(2) == 0);
         send_byte(pick_next_byte());
      end

      // Close the packet in flight so that the bad id arrives at a header.
      while (sb.state != ST_MID || sb.marker_held) send_byte(pick_next_byte());

      // An unknown id halts the block for the rest of the run.
      if ($urandom_range(1) == 0) begin
         if ($urandom_range(1) == 0) begin
            bad_byte = NOT_AN_ID;
         end else begin
            do bad_byte = 8'($urandom); while (sb.machine_slot(bad_byte) != N_MACHINE);
         end
         send_byte(bad_byte);
      end else begin
         send_byte(pick_next_byte());
         do bad_byte = 8'($urandom); while (sb.command_slot(bad_byte) != N_COMMAND);
         send_byte(bad_byte);
      end
      // These must be dropped without any result.
      repeat (6) send_byte(8'($urandom));
      push <= 1'b0;

      drain_wait = 0;
      while (sb.pending_rsp.size() != 0 && drain_wait < 20000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (20) @(posedge clock);
      sb.check_drained();

      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Result side: check each transfer, then stall at random outside steady stretches.
   initial begin
      int      stall;
      int      cycle_count;
      rsp_type got;
      pop        <= 1'b0;
      stall       = 0;
      cycle_count = 0;
      steady_out  = 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (pop && !empty) begin
            got.kind          = rsp_kind;
            got.value         = rsp_value;
            got.direction     = rsp_direction;
            got.command_index = rsp_command_index;
            got.resync        = rsp_resync;
            got.error_code    = rsp_error_code;
            got.last          = rsp_last;
            sb.check_result(got);
         end
         cycle_count++;
         if (cycle_count % 300 == 0) steady_out = ($urandom_range(2) == 0);
         if (stall > 0) begin
            pop <= 1'b0;
            stall--;
         end else begin
            pop <= 1'b1;
            stall = steady_out ? 0 : pick_gap();
         end
         @(posedge clock);
      end
   end

   // Watchdog against a hung handshake.
   initial begin
      #10ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
